// ===== sv/hssfi_pkg.sv =====
// ----------------------------------------------------------------------------
// hssfi_pkg: shared types, constants and hash functions
// Status codes, default sizes and the single-step mixing functions; the
// find-or-insert set uses all of them, its checker the codes and widths.
// ----------------------------------------------------------------------------
package hssfi_pkg;

   localparam int KEY_WORDS_DEF  = 10;
   localparam int TABLE_BITS_DEF = 12;
   localparam int LINE_SLOTS_DEF = 16;
   localparam int MAX_REHASH_DEF = 64;

   localparam int          SLOT_W         = 12;
   localparam int          CFG_W          = 4;
   localparam logic [3:0]  TABLE_BITS_RST = 4'd12;
   localparam int          TABLE_BITS_MIN = 4;

   localparam logic [31:0] FP_EMPTY = 32'h0000_0000;
   localparam logic [31:0] FP_TOMB  = 32'h0000_0001;
   localparam logic [31:0] FP_USED  = 32'h8000_0000;

   typedef enum logic [1:0] {
      STATUS_NEW     = 2'd0,
      STATUS_PRESENT = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      OP_WORD  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // One key word folded into the running hash (low half, then high half).
   function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
      logic [31:0] a;
      logic [31:0] t;
      logic [31:0] b;
      a = h + {16'd0, w[15:0]};
      t = ({16'd0, w[31:16]} << 11) ^ a;
      b = (a << 16) ^ t;
      return b + (b >> 11);
   endfunction

   // One of the six avalanche steps.
   function automatic logic [31:0] aval_step(input logic [31:0] h, input logic [2:0] step);
      logic [31:0] r;
      unique case (step)
         3'd0:    r = h ^ (h << 3);
         3'd1:    r = h + (h >> 5);
         3'd2:    r = h ^ (h << 4);
         3'd3:    r = h + (h >> 17);
         3'd4:    r = h ^ (h << 25);
         default: r = h + (h >> 6);
      endcase
      return r;
   endfunction

endpackage

// ===== sv/hashed_state_set_find_or_insert.sv =====
// ----------------------------------------------------------------------------
// hashed_state_set_find_or_insert: find-or-insert set of key vectors
// Open-addressing hash set with line probing, tombstone reuse and rehash.
// ----------------------------------------------------------------------------
// Feed a key as KEY_WORDS items, one 32-bit word each; the item that completes
// the key returns one result (new, present or full) with its slot, and all
// other items return nothing. A clear item empties the table. One sequencer
// drives a single hash unit, the fingerprint memory port and the key memory
// port, and req_stall stays high while it works. Per key it collects the
// words, hashes them and runs the avalanche steps, finds the line start,
// reads and checks slots in turn, compares the stored key word by word on a
// fingerprint hit, stores the key words and fingerprint, and posts the
// result; a full line repeats hashing and probing, up to MAX_REHASH times.
// After reset, and after every clear item, the block sweeps every slot of
// the fingerprint memory before it takes items; csr writes are taken at any
// time.
module hashed_state_set_find_or_insert #(
   parameter int KEY_WORDS  = hssfi_pkg::KEY_WORDS_DEF,
   parameter int TABLE_BITS = hssfi_pkg::TABLE_BITS_DEF,
   parameter int LINE_SLOTS = hssfi_pkg::LINE_SLOTS_DEF,
   parameter int MAX_REHASH = hssfi_pkg::MAX_REHASH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [31:0]                   req_key_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [hssfi_pkg::SLOT_W-1:0]  rsp_slot,
   input  logic                          csr_write_enable,
   input  logic [hssfi_pkg::CFG_W-1:0]   csr_write_data
);

   localparam int SLOTS   = 1 << TABLE_BITS;
   localparam int KIDX_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int WC_W    = $clog2(KEY_WORDS + 1);
   localparam int KADDR_W = (SLOTS * KEY_WORDS > 1) ? $clog2(SLOTS * KEY_WORDS) : 1;
   localparam int PC_W    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
   localparam int TRY_W   = $clog2(MAX_REHASH + 1);
   localparam int BITS_W  = $clog2(TABLE_BITS + 1);
   localparam int ENT_W   = TABLE_BITS + 1;
   localparam int LD_W    = TABLE_BITS + 3;
   localparam int WIDE_W  = TABLE_BITS + 8;
   localparam int LS_LOG  = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 0;
   localparam int RCP_W   = TABLE_BITS + 1;
   localparam int PROD_W  = TABLE_BITS + RCP_W;
   localparam logic [RCP_W-1:0] LINE_RCP =
      RCP_W'(((64'd1 << (TABLE_BITS + LS_LOG)) + 64'(LINE_SLOTS - 1)) / 64'(LINE_SLOTS));

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_AVAL, ST_DIV, ST_PRD, ST_PCHK,
      ST_CRD, ST_CCHK, ST_STKEY, ST_STFP, ST_TOMB, ST_FIN
   } state_type;

   state_type               state_ff;
   logic [3:0]              table_bits_ff;
   logic [31:0]             key_buffer_ff [KEY_WORDS];
   logic [WC_W-1:0]         word_count_ff;
   logic [ENT_W-1:0]        entry_count_ff;
   logic [TABLE_BITS-1:0]   clr_ff;
   logic [31:0]             hash_ff;
   logic [31:0]             fp_ff;
   logic [KIDX_W-1:0]       kidx_ff;
   logic [2:0]              aval_ff;
   logic [TRY_W-1:0]        tries_ff;
   logic [TABLE_BITS-1:0]   ref_ff;
   logic [TABLE_BITS-1:0]   begin_ff;
   logic [ENT_W-1:0]        end_ff;
   logic [PC_W-1:0]         pc_ff;
   logic                    have_tomb_ff;
   logic [TABLE_BITS-1:0]   tomb_ff;
   logic [TABLE_BITS-1:0]   target_ff;
   logic                    new_ff;
   logic [1:0]              res_status_ff;
   logic [TABLE_BITS-1:0]   res_slot_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [hssfi_pkg::SLOT_W-1:0] rsp_slot_ff;

   // memories
   logic [31:0] fp_mem [SLOTS];
   logic [31:0] ks_mem [SLOTS * KEY_WORDS];
   logic [31:0] fp_rd_ff;
   logic [31:0] ks_rd_ff;

   logic                  fp_we;
   logic [TABLE_BITS-1:0] fp_waddr;
   logic [31:0]           fp_wdata;
   logic [TABLE_BITS-1:0] fp_raddr;
   logic                  ks_we;
   logic [KADDR_W-1:0]    ks_waddr;
   logic [KADDR_W-1:0]    ks_raddr;

   // derived table geometry
   logic [BITS_W-1:0]     bits;
   logic [ENT_W-1:0]      size;
   logic [TABLE_BITS-1:0] mask;
   logic                  load_full;

   logic                  req_accept;
   logic                  key_done;
   logic [31:0]           kbuf_word;
   logic [31:0]           hash_step;
   logic [31:0]           aval_out;
   logic [PROD_W-1:0]     line_prod;
   logic [TABLE_BITS-1:0] line_q;
   logic [TABLE_BITS-1:0] begin_in;
   logic [WIDE_W-1:0]     end_wide;
   logic [ENT_W-1:0]      end_in;
   logic [WIDE_W-1:0]     ref_inc;
   logic [TABLE_BITS-1:0] ref_next;
   logic                  line_done;
   logic                  rehash_left;
   logic                  out_free;
   logic                  kidx_last;

   always_comb begin
      priority if (table_bits_ff < 4'(hssfi_pkg::TABLE_BITS_MIN)) begin
         bits = BITS_W'(hssfi_pkg::TABLE_BITS_MIN);
      end else if (int'(table_bits_ff) > TABLE_BITS) begin
         bits = BITS_W'(TABLE_BITS);
      end else begin
         bits = BITS_W'(table_bits_ff);
      end
   end

   assign size      = ENT_W'(1) << bits;
   assign mask      = TABLE_BITS'(size - ENT_W'(1));
   assign load_full = (LD_W'(entry_count_ff) << 2) >= (LD_W'(size) * LD_W'(3));

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign key_done   = req_accept && (req_operation == hssfi_pkg::OP_WORD)
                       && (word_count_ff == WC_W'(KEY_WORDS - 1));
   assign kbuf_word  = key_buffer_ff[kidx_ff];
   assign kidx_last  = (kidx_ff == KIDX_W'(KEY_WORDS - 1));
   assign hash_step  = hssfi_pkg::mix_word(hash_ff, kbuf_word);
   assign aval_out   = hssfi_pkg::aval_step(hash_ff, aval_ff);

   // line start: quotient of the home slot by the line size through a
   // rounded-up reciprocal, exact over the whole slot range
   assign line_prod = PROD_W'(ref_ff) * PROD_W'(LINE_RCP);
   assign line_q    = TABLE_BITS'(line_prod >> (TABLE_BITS + LS_LOG));
   assign begin_in  = TABLE_BITS'(WIDE_W'(line_q) * WIDE_W'(LINE_SLOTS));
   assign end_wide  = WIDE_W'(begin_in) + WIDE_W'(LINE_SLOTS);
   assign end_in    = (end_wide > WIDE_W'(size)) ? size : ENT_W'(end_wide);

   // wrap inside the line
   assign ref_inc  = WIDE_W'(ref_ff) + WIDE_W'(1);
   assign ref_next = (ref_inc == WIDE_W'(end_ff)) ? begin_ff : TABLE_BITS'(ref_inc);
   assign line_done   = (pc_ff == PC_W'(LINE_SLOTS - 1));
   assign rehash_left = (tries_ff < TRY_W'(MAX_REHASH));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // memory port control
   always_comb begin
      fp_we    = 1'b0;
      fp_waddr = target_ff;
      fp_wdata = fp_ff;
      ks_we    = 1'b0;
      fp_raddr = ref_ff;
      ks_waddr = KADDR_W'(KADDR_W'(target_ff) * KADDR_W'(KEY_WORDS) + KADDR_W'(kidx_ff));
      ks_raddr = KADDR_W'(KADDR_W'(ref_ff) * KADDR_W'(KEY_WORDS) + KADDR_W'(kidx_ff));
      unique case (state_ff)
         ST_CLEAR: begin
            fp_we    = 1'b1;
            fp_waddr = clr_ff;
            fp_wdata = hssfi_pkg::FP_EMPTY;
         end
         ST_STKEY: ks_we = 1'b1;
         ST_STFP:  fp_we = 1'b1;
         ST_TOMB: begin
            fp_we    = 1'b1;
            fp_waddr = ref_ff;
            fp_wdata = hssfi_pkg::FP_TOMB;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fp_we) begin
         fp_mem[fp_waddr] <= fp_wdata;
      end
      fp_rd_ff <= fp_mem[fp_raddr];
   end

   always_ff @(posedge clock) begin
      if (ks_we) begin
         ks_mem[ks_waddr] <= kbuf_word;
      end
      ks_rd_ff <= ks_mem[ks_raddr];
   end

   // key word capture
   always_ff @(posedge clock) begin
      if (req_accept && (req_operation == hssfi_pkg::OP_WORD)) begin
         key_buffer_ff[word_count_ff[KIDX_W-1:0]] <= req_key_word;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         table_bits_ff  <= hssfi_pkg::TABLE_BITS_RST;
         word_count_ff  <= '0;
         entry_count_ff <= '0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            table_bits_ff <= csr_write_data;
         end
         // drop the result once taken, unless a new one is posted now
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + TABLE_BITS'(1);
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_operation == hssfi_pkg::OP_CLEAR) begin
                     word_count_ff  <= '0;
                     entry_count_ff <= '0;
                     clr_ff         <= '0;
                     state_ff       <= ST_CLEAR;
                  end else if (key_done) begin
                     word_count_ff <= '0;
                     hash_ff       <= '0;
                     kidx_ff       <= '0;
                     tries_ff      <= '0;
                     have_tomb_ff  <= 1'b0;
                     if (load_full) begin
                        res_status_ff <= hssfi_pkg::STATUS_FULL;
                        res_slot_ff   <= '0;
                        state_ff      <= ST_FIN;
                     end else begin
                        state_ff <= ST_HASH;
                     end
                  end else begin
                     word_count_ff <= word_count_ff + WC_W'(1);
                  end
               end
            end
            ST_HASH: begin
               hash_ff <= hash_step;
               kidx_ff <= kidx_ff + KIDX_W'(1);
               if (kidx_last) begin
                  aval_ff  <= '0;
                  state_ff <= ST_AVAL;
               end
            end
            ST_AVAL: begin
               hash_ff <= aval_out;
               aval_ff <= aval_ff + 3'd1;
               if (aval_ff == 3'd5) begin
                  if (tries_ff == '0) begin
                     fp_ff <= aval_out | hssfi_pkg::FP_USED;
                  end
                  ref_ff   <= aval_out[TABLE_BITS-1:0] & mask;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               begin_ff <= begin_in;
               end_ff   <= end_in;
               pc_ff    <= '0;
               state_ff <= ST_PRD;
            end
            ST_PRD: state_ff <= ST_PCHK;
            ST_PCHK, ST_CCHK: begin
               // decide: take an empty slot, compare more, report a match, or advance, rehash or give up
               priority if (state_ff == ST_PCHK && fp_rd_ff == hssfi_pkg::FP_EMPTY) begin
                  target_ff <= have_tomb_ff ? tomb_ff : ref_ff;
                  new_ff    <= 1'b1;
                  kidx_ff   <= '0;
                  state_ff  <= ST_STKEY;
               end else if (state_ff == ST_PCHK && fp_rd_ff == fp_ff) begin
                  kidx_ff  <= '0;
                  state_ff <= ST_CRD;
               end else if (state_ff == ST_CCHK && ks_rd_ff == kbuf_word && !kidx_last) begin
                  kidx_ff  <= kidx_ff + KIDX_W'(1);
                  state_ff <= ST_CRD;
               end else if (state_ff == ST_CCHK && ks_rd_ff == kbuf_word) begin
                  if (have_tomb_ff) begin
                     target_ff <= tomb_ff;
                     new_ff    <= 1'b0;
                     kidx_ff   <= '0;
                     state_ff  <= ST_STKEY;
                  end else begin
                     res_status_ff <= hssfi_pkg::STATUS_PRESENT;
                     res_slot_ff   <= ref_ff;
                     state_ff      <= ST_FIN;
                  end
               end else begin
                  if (state_ff == ST_PCHK && !have_tomb_ff
                      && fp_rd_ff == hssfi_pkg::FP_TOMB) begin
                     have_tomb_ff <= 1'b1;
                     tomb_ff      <= ref_ff;
                  end
                  if (!line_done) begin
                     ref_ff   <= ref_next;
                     pc_ff    <= pc_ff + PC_W'(1);
                     state_ff <= ST_PRD;
                  end else if (rehash_left) begin
                     hash_ff  <= hash_ff + 32'(tries_ff);
                     tries_ff <= tries_ff + TRY_W'(1);
                     kidx_ff  <= '0;
                     state_ff <= ST_HASH;
                  end else begin
                     res_status_ff <= hssfi_pkg::STATUS_FULL;
                     res_slot_ff   <= '0;
                     state_ff      <= ST_FIN;
                  end
               end
            end
            ST_CRD: state_ff <= ST_CCHK;
            ST_STKEY: begin
               kidx_ff <= kidx_ff + KIDX_W'(1);
               if (kidx_last) begin
                  state_ff <= ST_STFP;
               end
            end
            ST_STFP: begin
               res_status_ff <= new_ff ? hssfi_pkg::STATUS_NEW : hssfi_pkg::STATUS_PRESENT;
               res_slot_ff   <= target_ff;
               if (new_ff) begin
                  entry_count_ff <= entry_count_ff + ENT_W'(1);
                  state_ff       <= ST_FIN;
               end else begin
                  state_ff <= ST_TOMB;
               end
            end
            ST_TOMB: state_ff <= ST_FIN;
            ST_FIN: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= hssfi_pkg::SLOT_W'(res_slot_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

// ===== sv/hssfi_checker.sv =====
// ----------------------------------------------------------------------------
// hssfi_checker: port-level checks for the find-or-insert set
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module hssfi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_status,
   input logic [hssfi_pkg::SLOT_W-1:0]  rsp_slot
);

   // status is one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == hssfi_pkg::STATUS_NEW
                     || rsp_status == hssfi_pkg::STATUS_PRESENT
                     || rsp_status == hssfi_pkg::STATUS_FULL))
      else $error("undefined status code");

   // a full answer reports slot zero
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == hssfi_pkg::STATUS_FULL) |-> (rsp_slot == '0))
      else $error("full answer with nonzero slot");

   // a clear item starts the sweep, so the input stalls next cycle
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation == hssfi_pkg::OP_CLEAR) |=> req_stall)
      else $error("input ready right after a clear");

   // the sweep after reset keeps the input stalled
   a_reset_stalls: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input ready right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot)))
      else $error("stalled result changed");

endmodule

bind hashed_state_set_find_or_insert hssfi_checker u_hssfi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_slot      (rsp_slot)
);
